// ===== sv/pdf_pkg.sv =====
// pdf_pkg: shared constants and types of the packet duplicate filter
// no dependencies
`default_nettype none

package pdf_pkg;

    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME    = 32'd16777619;
    localparam logic [31:0] WINDOW_RESET = 32'd2000;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_ENABLE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_MS     = 1'd1;

    // input item kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_CONFIRM = 1'b1;

    // finished packet hash heading for the table lookup
    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
        logic [31:0] now;
    } t_chk_req;

    // write of the pending hash into the oldest slot
    typedef struct packed {
        logic        en;
        logic [31:0] hash;
        logic [31:0] stamp;
    } t_slot_wr;

endpackage

`default_nettype wire

// ===== sv/pdf_hash_stage.sv =====
// pdf_hash_stage: input register, fnv-1a byte fold, running and pending hash
// depends on pdf_pkg
`default_nettype none

module pdf_hash_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_kind,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_last,
    input  wire logic [31:0]       i_now,
    output pdf_pkg::t_chk_req      o_chk,
    input  wire logic              i_chk_ready,
    output pdf_pkg::t_slot_wr      o_slot_wr
);
    import pdf_pkg::*;

    logic        r_in_valid;
    logic        r_in_kind;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [31:0] r_in_now;
    logic [31:0] r_running;
    logic [31:0] r_pending;

    logic        w_needs_chk;
    logic        w_in_free;
    logic        w_in_adv;
    logic        w_accept;
    logic [31:0] w_fold;

    assign w_fold      = (r_running ^ {24'd0, r_in_byte}) * FNV_PRIME;
    assign w_needs_chk = (r_in_kind == KIND_BYTE) && r_in_last;
    // a confirm waits until any earlier lookup has been evaluated
    assign w_in_free   = !r_in_valid || !(w_needs_chk || (r_in_kind == KIND_CONFIRM))
                         || i_chk_ready;
    assign w_in_adv    = r_in_valid && w_in_free;
    assign w_accept    = i_valid && w_in_free;
    assign o_ready     = w_in_free;

    assign o_chk.valid = r_in_valid && w_needs_chk;
    assign o_chk.hash  = w_fold;
    assign o_chk.now   = r_in_now;

    assign o_slot_wr.en    = w_in_adv && (r_in_kind == KIND_CONFIRM);
    assign o_slot_wr.hash  = r_pending;
    assign o_slot_wr.stamp = r_in_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_running  <= FNV_BASIS;
            r_pending  <= 32'd0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_in_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_in_adv && (r_in_kind == KIND_BYTE)) begin
                if (r_in_last) begin
                    r_running <= FNV_BASIS;
                    r_pending <= w_fold;
                end else begin
                    r_running <= w_fold;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_byte;
            r_in_last <= i_last;
            r_in_now  <= i_now;
        end
    end

    // a finished packet restarts the hash and becomes the pending hash
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_adv && w_needs_chk) |=> (r_running == FNV_BASIS) && (r_pending == $past(w_fold)))
        else $error("hash not restarted after last byte");

endmodule

`default_nettype wire

// ===== sv/pdf_slot_table.sv =====
// pdf_slot_table: remembered hash and time slots, oldest-slot pick, window match
// depends on pdf_pkg
`default_nettype none

module pdf_slot_table #(
    parameter int unsigned SLOTS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  pdf_pkg::t_slot_wr      i_wr,
    input  wire logic [31:0]       i_q_hash,
    input  wire logic [31:0]       i_q_now,
    input  wire logic [31:0]       i_window,
    output logic                   o_match
);
    import pdf_pkg::*;

    localparam int unsigned LEVELS = $clog2(SLOTS);
    localparam int unsigned LEAVES = 1 << LEVELS;
    localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [31:0]      r_slot_hash [SLOTS];
    logic [31:0]      r_slot_time [SLOTS];

    logic [31:0]      w_node_time [2*LEAVES];
    logic [IDX_W-1:0] w_node_idx  [2*LEAVES];
    logic [SLOTS-1:0] w_hit;

    assign w_node_time[0] = '1;
    assign w_node_idx[0]  = '0;

    // leaves, padding entries never win over a real slot
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < SLOTS) begin : g_real
            assign w_node_time[LEAVES+j] = r_slot_time[j];
            assign w_node_idx[LEAVES+j]  = IDX_W'(j);
        end else begin : g_pad
            assign w_node_time[LEAVES+j] = '1;
            assign w_node_idx[LEAVES+j]  = '0;
        end
    end

    // minimum tree, left side keeps ties so the lowest index wins
    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        logic w_right;
        assign w_right        = w_node_time[2*n+1] < w_node_time[2*n];
        assign w_node_time[n] = w_right ? w_node_time[2*n+1] : w_node_time[2*n];
        assign w_node_idx[n]  = w_right ? w_node_idx[2*n+1] : w_node_idx[2*n];
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_cmp
        logic [31:0] w_age;
        assign w_age    = i_q_now - r_slot_time[i];
        assign w_hit[i] = (r_slot_hash[i] == i_q_hash) && (w_age <= i_window);
    end

    assign o_match = |w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_hash[i] <= 32'd0;
                r_slot_time[i] <= 32'd0;
            end
        end else if (i_wr.en) begin
            r_slot_hash[w_node_idx[1]] <= i_wr.hash;
            r_slot_time[w_node_idx[1]] <= i_wr.stamp;
        end
    end

endmodule

`default_nettype wire

// ===== sv/packet_duplicate_filter_top.sv =====
// a last byte's result passes through the input, lookup and output registers before it is valid
// throughput: one input transfer per cycle while the input is not stalled, packet bytes and confirms alike
// stalls reach the input only when a finished packet waits at the lookup and output
// reset clears the slot table, running hash to the fnv offset basis, pending hash to zero
// reset sets repeat_enable to one and window_ms to 2000
// depends on pdf_pkg, pdf_hash_stage, pdf_slot_table
`default_nettype none

module packet_duplicate_filter_top #(
    parameter int unsigned SLOTS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pdf_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [31:0]                     i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [39:0]                     s_axis_tdata,  // data_byte, now_ms
    input  wire logic                            s_axis_tlast,
    input  wire logic                            s_axis_tuser,  // kind
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [39:0]                          m_axis_tdata   // packet_hash, repeat_res
);
    import pdf_pkg::*;

    logic        r_repeat_enable;
    logic [31:0] r_window_ms;

    logic        r_chk_valid;
    logic [31:0] r_chk_hash;
    logic [31:0] r_chk_now;
    logic        r_out_valid;
    logic [31:0] r_out_hash;
    logic        r_out_repeat;

    t_chk_req    w_chk;
    t_slot_wr    w_slot_wr;
    logic        w_match;
    logic        w_out_free;
    logic        w_chk_free;
    logic        w_chk_load;
    logic        w_out_load;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_chk_free = !r_chk_valid || w_out_free;
    assign w_chk_load = w_chk.valid && w_chk_free;
    assign w_out_load = r_chk_valid && w_out_free;

    pdf_hash_stage u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_byte      (s_axis_tdata[7:0]),
        .i_last      (s_axis_tlast),
        .i_now       (s_axis_tdata[39:8]),
        .o_chk       (w_chk),
        .i_chk_ready (w_chk_free),
        .o_slot_wr   (w_slot_wr)
    );

    pdf_slot_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_slot_wr),
        .i_q_hash (r_chk_hash),
        .i_q_now  (r_chk_now),
        .i_window (r_window_ms),
        .o_match  (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_enable <= 1'b1;
            r_window_ms     <= WINDOW_RESET;
            r_chk_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_REPEAT_ENABLE: r_repeat_enable <= i_cfg_data[0];
                    CFG_WINDOW_MS:     r_window_ms     <= i_cfg_data;
                    default:           ;
                endcase
            end
            if (w_chk_load) begin
                r_chk_valid <= 1'b1;
            end else if (w_out_load) begin
                r_chk_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_chk_load) begin
            r_chk_hash <= w_chk.hash;
            r_chk_now  <= w_chk.now;
        end
        if (w_out_load) begin
            r_out_hash   <= r_chk_hash;
            r_out_repeat <= r_repeat_enable && !w_match;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_repeat, r_out_hash};

    // input stalls only behind a full lookup stage and a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_chk_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // every result comes from the lookup stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_chk_valid))
        else $error("result appeared without a lookup");

    // a waiting lookup is never dropped while the output is blocked
    a_chk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chk_valid && r_out_valid && !m_axis_tready) |=> r_chk_valid)
        else $error("lookup lost during output stall");

endmodule

`default_nettype wire
